@@ src/grid_ray_distance_probe_top_macros.svh @@
// Assertion macros for the grid ray distance probe checker.
// Clock and reset are taken from the scope where a macro is used (clock, reset).
`ifndef GRID_RAY_DISTANCE_PROBE_TOP_MACROS_SVH
`define GRID_RAY_DISTANCE_PROBE_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset
`define GRDP_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define GRDP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/grdp_pkg.sv @@
// Shared constants for the grid ray distance probe: field widths, codes, defaults.
// No dependencies; used by the top level, its checker and the testbench.
package grdp_pkg;

   // Default sizing of the block
   localparam int MAP_SIDE_DEF       = 256;
   localparam int RAY_LIMIT_DEF      = 32;
   localparam int NUM_DIRECTIONS_DEF = 8;

   // Port field widths
   localparam int COORD_W     = 8;
   localparam int DIR_IDX_W   = 3;
   localparam int MOVE_CNT_W  = 6;
   localparam int DIST_W      = 22;
   localparam int SIZE_W      = 9;
   localparam int WEIGHT_W    = 16;
   localparam int DIR_TABLE_W = 32;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 32;

   // Signed walk coordinate: covers -2 .. 256 with margin
   localparam int POS_W = 12;

   // sqrt(2) in Q8 and the distance ceiling
   localparam int SQRT2_Q8 = 362;
   localparam int DIST_MAX = 4194303;

   // Register reset values
   localparam logic [SIZE_W-1:0]      MAP_WIDTH_RST  = 9'd256;
   localparam logic [SIZE_W-1:0]      MAP_HEIGHT_RST = 9'd256;
   localparam logic [WEIGHT_W-1:0]    WEIGHT_RST     = 16'd256;
   localparam logic [DIR_TABLE_W-1:0] DIR_TABLE_RST  = 32'hDF75C341;

   // Request kinds
   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAP_WIDTH  = 2'd0,
      CSR_MAP_HEIGHT = 2'd1,
      CSR_WEIGHT     = 2'd2,
      CSR_DIR_TABLE  = 2'd3
   } csr_index_type;

endpackage

@@ src/grid_ray_distance_probe_top.sv @@
// Occupancy grid ray probe: one-bit grid memory, ray walk sequencer, distance scaling (grdp_pkg).
// Write item: no result; the next item can be taken on the following cycle.
// Query: for each direction in turn a launch, a walk of at most RAY_LIMIT moves, a multiply,
//   a scale and an emit step; no further request is taken until the last result is emitted,
//   and a stalled result holds the emit step until it can go out.
// Reset: synchronous; a clearing pass over all MAP_SIDE*MAP_SIDE cells frees every cell first.
module grid_ray_distance_probe_top #(
   parameter int MAP_SIDE       = grdp_pkg::MAP_SIDE_DEF,
   parameter int RAY_LIMIT      = grdp_pkg::RAY_LIMIT_DEF,
   parameter int NUM_DIRECTIONS = grdp_pkg::NUM_DIRECTIONS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_type,
   input  logic [grdp_pkg::COORD_W-1:0]        req_cell_x,
   input  logic [grdp_pkg::COORD_W-1:0]        req_cell_y,
   input  logic                                req_blocked,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [grdp_pkg::DIR_IDX_W-1:0]      rsp_direction_index,
   output logic [grdp_pkg::MOVE_CNT_W-1:0]     rsp_move_count,
   output logic [grdp_pkg::DIST_W-1:0]         rsp_weighted_distance,
   output logic                                rsp_last,
   // register write channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [grdp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [grdp_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int POS_W  = grdp_pkg::POS_W;
   localparam int DEPTH  = MAP_SIDE * MAP_SIDE;
   localparam int AW     = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(RAY_LIMIT + 1);
   localparam int PROD_W = CNT_W + grdp_pkg::WEIGHT_W;
   localparam int EXT_W  = PROD_W + 9;

   typedef enum logic [6:0] {
      ST_CLEAR  = 7'b0000001,
      ST_IDLE   = 7'b0000010,
      ST_LAUNCH = 7'b0000100,
      ST_WALK   = 7'b0001000,
      ST_MUL    = 7'b0010000,
      ST_SCALE  = 7'b0100000,
      ST_EMIT   = 7'b1000000
   } state_type;

   typedef logic signed [POS_W-1:0] pos_type;

   // Control and configuration registers
   state_type                               state_ff, state_in;
   logic [AW-1:0]                           clr_ff, clr_in;
   logic [grdp_pkg::SIZE_W-1:0]             map_width_ff, map_height_ff;
   logic [grdp_pkg::WEIGHT_W-1:0]           weight_ff;
   logic [grdp_pkg::DIR_TABLE_W-1:0]        dir_table_ff;
   logic [grdp_pkg::DIR_IDX_W-1:0]          dir_ff, dir_in;
   logic                                    rsp_valid_ff, rsp_valid_in;

   // Walk datapath registers
   logic [grdp_pkg::COORD_W-1:0]            start_x_ff, start_x_in, start_y_ff, start_y_in;
   pos_type                                 pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic [CNT_W-1:0]                        count_ff, count_in;
   logic [CNT_W-1:0]                        res_count_ff, res_count_in;
   logic [PROD_W-1:0]                       prod_ff, prod_in;
   logic [grdp_pkg::DIST_W-1:0]             dist_ff, dist_in;

   // Output registers
   logic [grdp_pkg::DIR_IDX_W-1:0]          rsp_dir_ff, rsp_dir_in;
   logic [grdp_pkg::MOVE_CNT_W-1:0]         rsp_cnt_ff, rsp_cnt_in;
   logic [grdp_pkg::DIST_W-1:0]             rsp_dist_ff, rsp_dist_in;
   logic                                    rsp_last_ff, rsp_last_in;

   // Grid memory
   logic                                    grid_mem [DEPTH];
   logic                                    mem_we;
   logic [AW-1:0]                           mem_waddr, mem_raddr;
   logic                                    mem_wdata;
   logic                                    rd_data_ff;

   // Combinational helpers
   pos_type                                 eff_w, eff_h, step_x, step_y, next_x, next_y;
   pos_type                                 start_px, start_py;
   logic [3:0]                              dir_entry;
   logic                                    out_free;
   logic [EXT_W-1:0]                        prod_ext, prod_scaled, dist_pre;

   function automatic logic is_outside(pos_type x, pos_type y, pos_type w, pos_type h);
      is_outside = x[POS_W-1] || y[POS_W-1] || (x >= w) || (y >= h);
   endfunction

   // Meaningful only for cells inside the grid, where the low bits carry the full coordinate
   function automatic logic [AW-1:0] cell_addr(pos_type x, pos_type y);
      cell_addr = AW'(int'(y[POS_W-2:0]) * MAP_SIDE + int'(x[POS_W-2:0]));
   endfunction

   // Sizes in use, capped at the stored grid
   assign eff_w = (int'(map_width_ff) > MAP_SIDE) ? POS_W'(MAP_SIDE)
                                                   : POS_W'(map_width_ff);
   assign eff_h = (int'(map_height_ff) > MAP_SIDE) ? POS_W'(MAP_SIDE)
                                                    : POS_W'(map_height_ff);

   // Step of the current direction, sign extended
   assign dir_entry = dir_table_ff[4*dir_ff +: 4];
   assign step_x    = {{(POS_W-2){dir_entry[1]}}, dir_entry[1:0]};
   assign step_y    = {{(POS_W-2){dir_entry[3]}}, dir_entry[3:2]};
   assign next_x    = pos_x_ff + step_x;
   assign next_y    = pos_y_ff + step_y;
   assign start_px  = POS_W'(start_x_ff);
   assign start_py  = POS_W'(start_y_ff);

   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Distance scaling: upper-half direction indexes (diagonal by default) take the extra sqrt(2) factor
   assign prod_ext    = EXT_W'(prod_ff);
   assign prod_scaled = (prod_ext * EXT_W'(grdp_pkg::SQRT2_Q8)) >> 8;
   assign dist_pre    = (int'(dir_ff) >= NUM_DIRECTIONS / 2) ? prod_scaled : prod_ext;

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      dir_in       = dir_ff;
      start_x_in   = start_x_ff;
      start_y_in   = start_y_ff;
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      count_in     = count_ff;
      res_count_in = res_count_ff;
      prod_in      = prod_ff;
      dist_in      = dist_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_dir_in   = rsp_dir_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_dist_in  = rsp_dist_ff;
      rsp_last_in  = rsp_last_ff;
      mem_we       = 1'b0;
      mem_waddr    = clr_ff;
      mem_wdata    = 1'b0;
      mem_raddr    = cell_addr(next_x, next_y);

      case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               if (req_type == grdp_pkg::REQ_QUERY) begin
                  start_x_in = req_cell_x;
                  start_y_in = req_cell_y;
                  dir_in     = '0;
                  state_in   = ST_LAUNCH;
               end else if (int'(req_cell_x) < MAP_SIDE && int'(req_cell_y) < MAP_SIDE) begin
                  mem_we    = 1'b1;
                  mem_waddr = cell_addr(POS_W'(req_cell_x), POS_W'(req_cell_y));
                  mem_wdata = req_blocked;
               end
            end
         end
         ST_LAUNCH: begin
            // read the start cell; outside start finishes at zero
            pos_x_in  = start_px;
            pos_y_in  = start_py;
            count_in  = '0;
            mem_raddr = cell_addr(start_px, start_py);
            if (is_outside(start_px, start_py, eff_w, eff_h)) begin
               res_count_in = '0;
               state_in     = ST_MUL;
            end else begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            // read data belongs to the cell at pos; one move per cycle
            if (rd_data_ff || count_ff == CNT_W'(RAY_LIMIT)) begin
               res_count_in = count_ff;
               state_in     = ST_MUL;
            end else begin
               pos_x_in = next_x;
               pos_y_in = next_y;
               count_in = count_ff + CNT_W'(1);
               if (is_outside(next_x, next_y, eff_w, eff_h)) begin
                  res_count_in = count_ff + CNT_W'(1);
                  state_in     = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            prod_in  = PROD_W'(res_count_ff) * PROD_W'(weight_ff);
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            dist_in  = (dist_pre > EXT_W'(grdp_pkg::DIST_MAX))
                       ? grdp_pkg::DIST_W'(grdp_pkg::DIST_MAX)
                       : grdp_pkg::DIST_W'(dist_pre);
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_dir_in   = dir_ff;
               rsp_cnt_in   = grdp_pkg::MOVE_CNT_W'(res_count_ff);
               rsp_dist_in  = dist_ff;
               rsp_last_in  = (dir_ff == grdp_pkg::DIR_IDX_W'(NUM_DIRECTIONS - 1));
               if (dir_ff == grdp_pkg::DIR_IDX_W'(NUM_DIRECTIONS - 1)) begin
                  state_in = ST_IDLE;
               end else begin
                  dir_in   = dir_ff + grdp_pkg::DIR_IDX_W'(1);
                  state_in = ST_LAUNCH;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         dir_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         dir_ff       <= dir_in;
      end
   end

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         map_width_ff  <= grdp_pkg::MAP_WIDTH_RST;
         map_height_ff <= grdp_pkg::MAP_HEIGHT_RST;
         weight_ff     <= grdp_pkg::WEIGHT_RST;
         dir_table_ff  <= grdp_pkg::DIR_TABLE_RST;
      end else if (csr_valid) begin
         case (grdp_pkg::csr_index_type'(csr_index))
            grdp_pkg::CSR_MAP_WIDTH:  map_width_ff  <= csr_data[grdp_pkg::SIZE_W-1:0];
            grdp_pkg::CSR_MAP_HEIGHT: map_height_ff <= csr_data[grdp_pkg::SIZE_W-1:0];
            grdp_pkg::CSR_WEIGHT:     weight_ff     <= csr_data[grdp_pkg::WEIGHT_W-1:0];
            grdp_pkg::CSR_DIR_TABLE:  dir_table_ff  <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // Datapath and output payload
   always_ff @(posedge clock) begin
      start_x_ff   <= start_x_in;
      start_y_ff   <= start_y_in;
      pos_x_ff     <= pos_x_in;
      pos_y_ff     <= pos_y_in;
      count_ff     <= count_in;
      res_count_ff <= res_count_in;
      prod_ff      <= prod_in;
      dist_ff      <= dist_in;
      rsp_dir_ff   <= rsp_dir_in;
      rsp_cnt_ff   <= rsp_cnt_in;
      rsp_dist_ff  <= rsp_dist_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // Grid memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         grid_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= grid_mem[mem_raddr];
   end

   assign req_ready             = (state_ff == ST_IDLE);
   assign csr_ready             = 1'b1;
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_direction_index   = rsp_dir_ff;
   assign rsp_move_count        = rsp_cnt_ff;
   assign rsp_weighted_distance = rsp_dist_ff;
   assign rsp_last              = rsp_last_ff;

endmodule

@@ src/grdp_checker.sv @@
// Port-level checker for the grid ray distance probe, bound to the top level.
// Depends on grdp_pkg and grid_ray_distance_probe_top_macros.svh.
`include "grid_ray_distance_probe_top_macros.svh"

module grdp_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              req_type,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [grdp_pkg::DIR_IDX_W-1:0]    rsp_direction_index,
   input logic [grdp_pkg::MOVE_CNT_W-1:0]   rsp_move_count,
   input logic [grdp_pkg::DIST_W-1:0]       rsp_weighted_distance,
   input logic                              rsp_last
);

   localparam int PAYLOAD_W = grdp_pkg::DIR_IDX_W + grdp_pkg::MOVE_CNT_W + grdp_pkg::DIST_W + 1;

   // Direction expected on the next result transfer
   logic [grdp_pkg::DIR_IDX_W-1:0] exp_dir_ff, exp_dir_in;

   // Shorthands for the properties
   logic                           query_xfer;
   logic                           rsp_stall;
   logic                           dir_match;
   logic [PAYLOAD_W-1:0]           rsp_payload;

   assign query_xfer  = req_valid && req_ready && (req_type == grdp_pkg::REQ_QUERY);
   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign dir_match   = (rsp_direction_index == exp_dir_ff);
   assign rsp_payload = {rsp_direction_index, rsp_move_count, rsp_weighted_distance, rsp_last};

   always_comb begin
      exp_dir_in = exp_dir_ff;
      if (rsp_valid && rsp_ready) begin
         exp_dir_in = rsp_last ? '0 : rsp_direction_index + grdp_pkg::DIR_IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_dir_ff <= '0;
      end else begin
         exp_dir_ff <= exp_dir_in;
      end
   end

   // A query holds off further requests while it walks
   `GRDP_ASSERT_NEXT(a_query_holds_req, query_xfer, !req_ready, "request taken during query walk")

   // Results of a query come out in direction order, restarting after the last
   `GRDP_ASSERT_IMPLY(a_dir_order, rsp_valid, dir_match, "result direction out of order")

   // A stalled result holds its payload
   `GRDP_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(rsp_payload), "payload changed")

endmodule

bind grid_ray_distance_probe_top grdp_checker u_grdp_checker (
   .clock                 (clock),
   .reset                 (reset),
   .req_valid             (req_valid),
   .req_ready             (req_ready),
   .req_type              (req_type),
   .rsp_valid             (rsp_valid),
   .rsp_ready             (rsp_ready),
   .rsp_direction_index   (rsp_direction_index),
   .rsp_move_count        (rsp_move_count),
   .rsp_weighted_distance (rsp_weighted_distance),
   .rsp_last              (rsp_last)
);

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for grid_ray_distance_probe_top: grid cell writes and eight-way
// ray queries, checked against an in-bench occupancy grid and ray walker.
// Depends on grdp_pkg and the grid_ray_distance_probe_top RTL.
module tb;

   localparam int RAYS        = grdp_pkg::NUM_DIRECTIONS_DEF;
   localparam int GRID_SIDE   = grdp_pkg::MAP_SIDE_DEF;
   localparam int MAX_MOVES   = grdp_pkg::RAY_LIMIT_DEF;
   localparam int CYCLE_LIMIT = 750000;  // clearing pass plus several times the slowest run
   localparam int SETTLE      = 300;     // a full eight-ray query with margin
   localparam int REPORT_MAX  = 10;

   localparam int COORD_W     = grdp_pkg::COORD_W;
   localparam int DIR_IDX_W   = grdp_pkg::DIR_IDX_W;
   localparam int MOVE_CNT_W  = grdp_pkg::MOVE_CNT_W;
   localparam int DIST_W      = grdp_pkg::DIST_W;
   localparam int SIZE_W      = grdp_pkg::SIZE_W;
   localparam int WEIGHT_W    = grdp_pkg::WEIGHT_W;
   localparam int DIR_TABLE_W = grdp_pkg::DIR_TABLE_W;
   localparam int CSR_DATA_W  = grdp_pkg::CSR_DATA_W;

   typedef struct packed {
      logic [DIR_IDX_W-1:0]  dir;
      logic [MOVE_CNT_W-1:0] moves;
      logic [DIST_W-1:0]     dist_q8;
      logic                  last;
   } ray_result_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic                    req_type = grdp_pkg::REQ_WRITE;
   logic [COORD_W-1:0]      req_cell_x = '0;
   logic [COORD_W-1:0]      req_cell_y = '0;
   logic                    req_blocked = 1'b0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [DIR_IDX_W-1:0]    rsp_direction_index;
   logic [MOVE_CNT_W-1:0]   rsp_move_count;
   logic [DIST_W-1:0]       rsp_weighted_distance;
   logic                    rsp_last;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   grdp_pkg::csr_index_type csr_index = grdp_pkg::CSR_MAP_WIDTH;
   logic [CSR_DATA_W-1:0]   csr_data = '0;

   // Predicted grid and register copies
   bit                      grid_cells [GRID_SIDE*GRID_SIDE];
   logic [SIZE_W-1:0]       cfg_width  = grdp_pkg::MAP_WIDTH_RST;
   logic [SIZE_W-1:0]       cfg_height = grdp_pkg::MAP_HEIGHT_RST;
   logic [WEIGHT_W-1:0]     cfg_weight = grdp_pkg::WEIGHT_RST;
   logic [DIR_TABLE_W-1:0]  cfg_steps  = grdp_pkg::DIR_TABLE_RST;

   ray_result_type          expected_rays [$];
   int unsigned             mismatch_count = 0;
   int unsigned             cycle_count = 0;
   int unsigned             rx_tick = 0;
   int                      burst_left = 0;

   grid_ray_distance_probe_top DUT (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_type              (req_type),
      .req_cell_x            (req_cell_x),
      .req_cell_y            (req_cell_y),
      .req_blocked           (req_blocked),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_direction_index   (rsp_direction_index),
      .rsp_move_count        (rsp_move_count),
      .rsp_weighted_distance (rsp_weighted_distance),
      .rsp_last              (rsp_last),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_data              (csr_data)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------- ray walker

   function automatic int clamp_side(logic [SIZE_W-1:0] v);
      return (v > GRID_SIDE) ? GRID_SIDE : int'(v);
   endfunction

   // A ray stops on a cell outside the area in use or on an obstacle
   function automatic bit stops_ray(int x, int y);
      if (x < 0 || y < 0) return 1'b1;
      if (x >= clamp_side(cfg_width) || y >= clamp_side(cfg_height)) return 1'b1;
      return grid_cells[y*GRID_SIDE + x];
   endfunction

   function automatic int ray_moves(int sx, int sy, logic [3:0] step_code);
      int dx, dy, x, y, n;
      dx = $signed(step_code[1:0]);
      dy = $signed(step_code[3:2]);
      x  = sx;
      y  = sy;
      n  = 0;
      if (stops_ray(x, y)) return 0;
      // the move that hits the obstacle or the edge is counted
      while (n < MAX_MOVES) begin
         x += dx;
         y += dy;
         n++;
         if (stops_ray(x, y)) break;
      end
      return n;
   endfunction

   function automatic void cast_rays(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
      ray_result_type  r;
      longint unsigned d;
      int              n;
      for (int i = 0; i < RAYS; i++) begin
         n = ray_moves(int'(x), int'(y), cfg_steps[4*i +: 4]);
         d = longint'(n) * cfg_weight;
         // upper half of the table (diagonal in the reset table) is scaled by sqrt(2) in Q8
         if (i >= RAYS/2) d = (d * grdp_pkg::SQRT2_Q8) >> 8;
         if (d > grdp_pkg::DIST_MAX) d = grdp_pkg::DIST_MAX;
         r.dir     = i[DIR_IDX_W-1:0];
         r.moves   = n[MOVE_CNT_W-1:0];
         r.dist_q8 = d[DIST_W-1:0];
         r.last    = (i == RAYS-1);
         expected_rays.insert(expected_rays.size(), r);
      end
   endfunction

   // ---------------------------------------------------------------- drivers

   // One request transfer; the sender runs in bursts with random gaps between them
   task automatic send_item(logic kind, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                            logic blk);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = $urandom_range(1, 12);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid   <= 1'b1;
      req_type    <= kind;
      req_cell_x  <= x;
      req_cell_y  <= y;
      req_blocked <= blk;
      do @(posedge clock); while (!req_ready);
      if (kind == grdp_pkg::REQ_WRITE)
         grid_cells[{y, x}] = blk;
      else
         cast_rays(x, y);
   endtask

   // Hold the sender off until every predicted ray has been checked
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_rays.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(grdp_pkg::csr_index_type idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         grdp_pkg::CSR_MAP_WIDTH:  cfg_width  = data[SIZE_W-1:0];
         grdp_pkg::CSR_MAP_HEIGHT: cfg_height = data[SIZE_W-1:0];
         grdp_pkg::CSR_WEIGHT:     cfg_weight = data[WEIGHT_W-1:0];
         grdp_pkg::CSR_DIR_TABLE:  cfg_steps  = data[DIR_TABLE_W-1:0];
         default: ;
      endcase
   endtask

   // Registers change only with no query in flight
   task automatic apply_config(logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h,
                               logic [WEIGHT_W-1:0] wt, logic [DIR_TABLE_W-1:0] steps);
      drain_results();
      csr_write(grdp_pkg::CSR_MAP_WIDTH, CSR_DATA_W'(w));
      csr_write(grdp_pkg::CSR_MAP_HEIGHT, CSR_DATA_W'(h));
      csr_write(grdp_pkg::CSR_WEIGHT, CSR_DATA_W'(wt));
      csr_write(grdp_pkg::CSR_DIR_TABLE, steps);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Receiver stall pattern: open, mostly ready, periodically ready, mostly stalled
   always @(negedge clock) begin
      rx_tick <= rx_tick + 1;
      case ((rx_tick / 256) % 4)
         0:       rsp_ready <= 1'b1;
         1:       rsp_ready <= ($urandom_range(0, 9) < 7);
         2:       rsp_ready <= (rx_tick % 3 == 0);
         default: rsp_ready <= ($urandom_range(0, 9) < 3);
      endcase
   end

   // ---------------------------------------------------------------- checker

   // Reports list fields as dir/moves/dist/last
   always @(posedge clock) begin : rsp_check
      ray_result_type got, want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_direction_index, rsp_move_count, rsp_weighted_distance, rsp_last};
         if (expected_rays.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
               $display("[%0t] unexpected ray transfer: %0d/%0d/%0d/%0b",
                        $time, got.dir, got.moves, got.dist_q8, got.last);
         end else begin
            want = expected_rays.pop_front();
            if (got.dir !== want.dir || got.moves !== want.moves ||
                got.dist_q8 !== want.dist_q8 || got.last !== want.last) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX)
                  $display("[%0t] ray mismatch: expected %0d/%0d/%0d/%0b, got %0d/%0d/%0d/%0b",
                           $time, want.dir, want.moves, want.dist_q8, want.last,
                           got.dir, got.moves, got.dist_q8, got.last);
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[%0t] run timed out after %0d cycles", $time, cycle_count);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------- tests

   // Reset register values, empty grid: rays run to the edge or the ray limit
   task automatic test_open_grid();
      apply_config(grdp_pkg::MAP_WIDTH_RST, grdp_pkg::MAP_HEIGHT_RST, grdp_pkg::WEIGHT_RST,
                   grdp_pkg::DIR_TABLE_RST);
      send_item(grdp_pkg::REQ_QUERY, 8'd0, 8'd0, 1'b0);
      send_item(grdp_pkg::REQ_QUERY, 8'd255, 8'd255, 1'b1);
      send_item(grdp_pkg::REQ_QUERY, 8'd128, 8'd128, 1'b0);
      send_item(grdp_pkg::REQ_QUERY, 8'd0, 8'd255, 1'b0);
      send_item(grdp_pkg::REQ_QUERY, 8'd255, 8'd0, 1'b1);
   endtask

   // Obstacles around a start cell, blocked start, then the start cell and one obstacle freed again
   task automatic test_obstacle_stops();
      send_item(grdp_pkg::REQ_WRITE, 8'd10, 8'd10, 1'b1);
      send_item(grdp_pkg::REQ_WRITE, 8'd8, 8'd12, 1'b1);
      send_item(grdp_pkg::REQ_WRITE, 8'd6, 8'd8, 1'b1);
      send_item(grdp_pkg::REQ_WRITE, 8'd9, 8'd9, 1'b1);
      send_item(grdp_pkg::REQ_QUERY, 8'd8, 8'd10, 1'b0);
      send_item(grdp_pkg::REQ_WRITE, 8'd255, 8'd255, 1'b1);
      send_item(grdp_pkg::REQ_QUERY, 8'd255, 8'd255, 1'b0);
      send_item(grdp_pkg::REQ_WRITE, 8'd255, 8'd255, 1'b0);
      send_item(grdp_pkg::REQ_QUERY, 8'd255, 8'd255, 1'b0);
      send_item(grdp_pkg::REQ_WRITE, 8'd10, 8'd10, 1'b0);
      send_item(grdp_pkg::REQ_QUERY, 8'd8, 8'd10, 1'b1);
   endtask

   // Grid size, weight and step table at their extremes
   task automatic test_size_and_step_extremes();
      // one-cell grid: start inside, start outside
      apply_config(9'd1, 9'd1, grdp_pkg::WEIGHT_RST, grdp_pkg::DIR_TABLE_RST);
      send_item(grdp_pkg::REQ_QUERY, 8'd0, 8'd0, 1'b0);
      send_item(grdp_pkg::REQ_QUERY, 8'd1, 8'd0, 1'b0);
      // zero width puts every cell outside
      apply_config(9'd0, 9'd5, 16'hFFFF, grdp_pkg::DIR_TABLE_RST);
      send_item(grdp_pkg::REQ_QUERY, 8'd0, 8'd0, 1'b0);
      // a cell beyond the area in use is still stored
      apply_config(9'd16, 9'd16, grdp_pkg::WEIGHT_RST, grdp_pkg::DIR_TABLE_RST);
      send_item(grdp_pkg::REQ_WRITE, 8'd20, 8'd3, 1'b1);
      // oversized sizes act as the full grid
      apply_config(9'd511, 9'd300, 16'hFFFF, grdp_pkg::DIR_TABLE_RST);
      send_item(grdp_pkg::REQ_QUERY, 8'd18, 8'd3, 1'b0);
      send_item(grdp_pkg::REQ_QUERY, 8'd255, 8'd255, 1'b0);
      // zero step walks in place up to the ray limit
      apply_config(9'd256, 9'd256, 16'hFFFF, 32'h0000_0000);
      send_item(grdp_pkg::REQ_QUERY, 8'd5, 8'd5, 1'b0);
      // largest negative step in both axes
      apply_config(9'd256, 9'd256, 16'h0001, 32'hAAAA_AAAA);
      send_item(grdp_pkg::REQ_QUERY, 8'd200, 8'd200, 1'b0);
      // zero weight
      apply_config(9'd256, 9'd256, 16'h0000, 32'h5555_5555);
      send_item(grdp_pkg::REQ_QUERY, 8'd100, 8'd100, 1'b0);
   endtask

   function automatic logic [SIZE_W-1:0] pick_size();
      case ($urandom_range(0, 9))
         0:       return 9'd1;
         1:       return 9'd256;
         2:       return SIZE_W'($urandom_range(257, 511));
         default: return SIZE_W'($urandom_range(4, 24));
      endcase
   endfunction

   function automatic logic [WEIGHT_W-1:0] pick_weight();
      case ($urandom_range(0, 5))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         default: return WEIGHT_W'($urandom_range(0, 65535));
      endcase
   endfunction

   // Mostly inside or just past the area in use, now and then anywhere
   function automatic logic [COORD_W-1:0] pick_coord(logic [SIZE_W-1:0] size);
      int hi;
      hi = (size > 254) ? 255 : int'(size) + 1;
      if ($urandom_range(0, 7) == 0) return COORD_W'($urandom_range(0, 255));
      return COORD_W'($urandom_range(0, hi));
   endfunction

   // Mixed cell writes and queries over several register settings
   task automatic test_random_traffic();
      logic [SIZE_W-1:0] w, h;
      int                pause_at;
      for (int phase = 0; phase < 4; phase++) begin
         w = pick_size();
         h = pick_size();
         apply_config(w, h, pick_weight(),
                      (phase == 0) ? grdp_pkg::DIR_TABLE_RST : $urandom());
         pause_at = $urandom_range(5, 30);
         for (int k = 0; k < 34; k++) begin
            if (k == pause_at) drain_results();
            if ($urandom_range(0, 99) < 55)
               send_item(grdp_pkg::REQ_WRITE, pick_coord(w), pick_coord(h),
                         $urandom_range(0, 99) < 50);
            else
               send_item(grdp_pkg::REQ_QUERY, pick_coord(w), pick_coord(h),
                         1'($urandom_range(0, 1)));
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_open_grid();
      test_obstacle_stops();
      test_size_and_step_extremes();
      test_random_traffic();

      drain_results();
      repeat (SETTLE) @(posedge clock);
      if (mismatch_count == 0 && expected_rays.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

@@ files.f @@
+incdir+src
src/grdp_pkg.sv
src/grid_ray_distance_probe_top.sv
src/grdp_checker.sv
verif/tb.sv
